[rtl/dfase_pkg.sv]
// Package for the DFA state-equivalence block: field widths, default sizes,
// opcodes, register indexes, controller states and the command/status structs.
// No dependencies.
package dfase_pkg;

    // Default sizes of the stored automaton.
    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_SYMBOLS_DEF = 8;

    // Fixed widths of the channel fields.
    localparam int OPCODE_W  = 2;
    localparam int STATE_W   = 4;
    localparam int SYMBOL_W  = 3;
    localparam int CLASS_W   = 5;

    // Configuration port.
    localparam int NSTATES_W  = 5;
    localparam int NSYMBOLS_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_TRANS  = 2'd0,
        OP_LOAD_ACCEPT = 2'd1,
        OP_RUN         = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_STATES  = 1'd0,
        REG_NUM_SYMBOLS = 1'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_TR,
        ST_MR,
        ST_UPD,
        ST_CNT_RD,
        ST_CNT,
        ST_EM_RD,
        ST_EM_LD
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_row;
        logic tr_rd;
        logic mx_rd;
        logic upd;
        logic clr_chg;
        logic row_rd;
        logic cnt_clr;
        logic cnt_inc;
        logic emit;
        logic emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic changed;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/dfase_item_if.sv]
// Input channel interface: valid/ready handshake with the load and run payload.
// Depends on dfase_pkg.
interface dfase_item_if
    import dfase_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [STATE_W-1:0]  state_index;
    logic [SYMBOL_W-1:0] symbol_index;
    logic [STATE_W-1:0]  target_state;
    logic                accept_flag;

    modport source (
        output valid, opcode, state_index, symbol_index, target_state, accept_flag,
        input  ready
    );
    modport sink (
        input  valid, opcode, state_index, symbol_index, target_state, accept_flag,
        output ready
    );
endinterface

[rtl/dfase_result_if.sv]
// Result channel interface: valid/ready handshake with one per-state result.
// Depends on dfase_pkg.
interface dfase_result_if
    import dfase_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] state_id;
    logic [STATE_W-1:0] representative;
    logic               is_leader;
    logic [CLASS_W-1:0] class_count;
    logic               last;

    modport source (
        output valid, state_id, representative, is_leader, class_count, last,
        input  ready
    );
    modport sink (
        input  valid, state_id, representative, is_leader, class_count, last,
        output ready
    );
endinterface

[rtl/dfase_ctrl.sv]
// Controller of the DFA state-equivalence block: configuration registers,
// loop counters and the sequencing state machine. Depends on dfase_pkg.
module dfase_ctrl
    import dfase_pkg::*;
#(
    parameter int MAX_STATES  = MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    localparam int SW = $clog2(MAX_STATES),
    localparam int CW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1,
    localparam int NW = $clog2(MAX_STATES + 1),
    localparam int MW = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  item_fire,
    input  logic [OPCODE_W-1:0]   item_opcode,
    output logic                  item_ready,
    output logic [NW-1:0]         n_used,
    output logic [SW-1:0]         i_idx,
    output logic [SW-1:0]         j_idx,
    output logic [CW-1:0]         c_idx,
    output dp_cmd_t               cmd,
    input  dp_status_t            status
);

    ctrl_state_t          state_reg, state_next;
    logic [NSTATES_W-1:0]  num_states_reg;
    logic [NSYMBOLS_W-1:0] num_symbols_reg;
    logic [SW-1:0]         i_reg, i_next;
    logic [SW-1:0]         j_reg, j_next;
    logic [CW-1:0]         c_reg, c_next;
    logic [MW-1:0]         m_used;
    logic                  last_i, last_j, last_c, pass_end;

    // Configuration registers; the user is to write them only while the block is idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg  <= NSTATES_W'(1);
            num_symbols_reg <= NSYMBOLS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_STATES:  num_states_reg  <= NSTATES_W'(cfg_wdata);
                REG_NUM_SYMBOLS: num_symbols_reg <= NSYMBOLS_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Counts in use: zero reads as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (num_states_reg == '0)
            n_used = NW'(1);
        else if (32'(num_states_reg) > MAX_STATES)
            n_used = NW'(MAX_STATES);
        else
            n_used = NW'(num_states_reg);

        if (num_symbols_reg == '0)
            m_used = MW'(1);
        else if (32'(num_symbols_reg) > MAX_SYMBOLS)
            m_used = MW'(MAX_SYMBOLS);
        else
            m_used = MW'(num_symbols_reg);
    end

    assign last_i   = (32'(i_reg) + 32'd1 == 32'(n_used));
    assign last_j   = (32'(j_reg) + 32'd1 == 32'(n_used));
    assign last_c   = (32'(c_reg) + 32'd1 == 32'(m_used));
    assign pass_end = last_i && last_j && last_c;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (item_fire && (item_opcode == OP_RUN))
                    state_next = ST_INIT;
            ST_INIT:
                if (last_i)
                    state_next = ST_TR;
            ST_TR:
                state_next = ST_MR;
            ST_MR:
                state_next = ST_UPD;
            ST_UPD:
                if (pass_end && !status.changed)
                    state_next = ST_CNT_RD;
                else
                    state_next = ST_TR;
            ST_CNT_RD:
                state_next = ST_CNT;
            ST_CNT:
                state_next = last_i ? ST_EM_RD : ST_CNT_RD;
            ST_EM_RD:
                state_next = ST_EM_LD;
            ST_EM_LD:
                if (status.out_free)
                    state_next = last_i ? ST_IDLE : ST_EM_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Loop counters: symbol outermost, then row state, then column state.
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        c_next = c_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                c_next = '0;
            end
            ST_INIT, ST_CNT:
                i_next = last_i ? '0 : i_reg + SW'(1);
            ST_UPD:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        i_next = '0;
                        c_next = last_c ? '0 : c_reg + CW'(1);
                    end
                    else
                        i_next = i_reg + SW'(1);
                end
                else
                    j_next = j_reg + SW'(1);
            end
            ST_EM_LD:
                if (status.out_free)
                    i_next = last_i ? '0 : i_reg + SW'(1);
            default: ;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        item_ready    = 1'b0;
        cmd.emit_last = last_i;
        unique case (state_reg)
            ST_IDLE:   item_ready = 1'b1;
            ST_INIT:
            begin
                cmd.init_row = 1'b1;
                cmd.cnt_clr  = 1'b1;
                cmd.clr_chg  = last_i;
            end
            ST_TR:     cmd.tr_rd = 1'b1;
            ST_MR:     cmd.mx_rd = 1'b1;
            ST_UPD:
            begin
                cmd.upd     = 1'b1;
                cmd.clr_chg = pass_end;
            end
            ST_CNT_RD: cmd.row_rd = 1'b1;
            ST_CNT:    cmd.cnt_inc = 1'b1;
            ST_EM_RD:  cmd.row_rd = 1'b1;
            ST_EM_LD:  cmd.emit = status.out_free;
            default: ;
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            c_reg     <= c_next;
        end
    end

    assign i_idx = i_reg;
    assign j_idx = j_reg;
    assign c_idx = c_reg;

endmodule

[rtl/dfase_dp.sv]
// Datapath of the DFA state-equivalence block: transition memory, accepting
// flags, pair matrix memory, class counter and result register. Depends on dfase_pkg.
module dfase_dp
    import dfase_pkg::*;
#(
    parameter int MAX_STATES  = MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    localparam int SW = $clog2(MAX_STATES),
    localparam int CW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1,
    localparam int NW = $clog2(MAX_STATES + 1),
    localparam int TD = MAX_STATES * MAX_SYMBOLS,
    localparam int AW = $clog2(TD)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic                item_fire,
    input  logic [OPCODE_W-1:0] item_opcode,
    input  logic [STATE_W-1:0]  item_state_index,
    input  logic [SYMBOL_W-1:0] item_symbol_index,
    input  logic [STATE_W-1:0]  item_target_state,
    input  logic                item_accept_flag,
    input  logic [NW-1:0]       n_used,
    input  logic [SW-1:0]       i_idx,
    input  logic [SW-1:0]       j_idx,
    input  logic [CW-1:0]       c_idx,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [STATE_W-1:0]  res_state_id,
    output logic [STATE_W-1:0]  res_representative,
    output logic                res_is_leader,
    output logic [CLASS_W-1:0]  res_class_count,
    output logic                res_last
);

    logic [STATE_W-1:0]    tr_mem [TD];
    logic [STATE_W-1:0]    ti_reg, tj_reg;
    logic [MAX_STATES-1:0] acc_reg;
    logic [MAX_STATES-1:0] mx_mem [MAX_STATES];
    logic [MAX_STATES-1:0] row_a_reg, row_b_reg;
    logic [MAX_STATES-1:0] used_mask, lower_mask, init_row;
    logic [MAX_STATES-1:0] mx_wdata;
    logic                  mx_we;
    logic                  st_ok, sym_ok, tr_we, acc_we;
    logic [AW-1:0]         tr_waddr, tr_raddr_i, tr_raddr_j;
    logic                  succ_ok, succ_marked, mark_now, leader;
    logic [SW-1:0]         rep;
    logic                  chg_reg;
    logic [NW-1:0]         cnt_reg;
    logic                  valid_reg;

    // Loads outside the stored automaton are dropped.
    assign st_ok    = (32'(item_state_index) < MAX_STATES);
    assign sym_ok   = (32'(item_symbol_index) < MAX_SYMBOLS);
    assign tr_we    = item_fire && (item_opcode == OP_LOAD_TRANS) && st_ok && sym_ok;
    assign acc_we   = item_fire && (item_opcode == OP_LOAD_ACCEPT) && st_ok;
    assign tr_waddr = AW'(32'(item_state_index) * MAX_SYMBOLS + 32'(item_symbol_index));
    assign tr_raddr_i = AW'(32'(i_idx) * MAX_SYMBOLS + 32'(c_idx));
    assign tr_raddr_j = AW'(32'(j_idx) * MAX_SYMBOLS + 32'(c_idx));

    // Transition memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (tr_we)
            tr_mem[tr_waddr] <= item_target_state;
        if (cmd.tr_rd)
        begin
            ti_reg <= tr_mem[tr_raddr_i];
            tj_reg <= tr_mem[tr_raddr_j];
        end
    end

    // Accepting flags.
    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_reg[SW'(item_state_index)] <= item_accept_flag;
    end

    // Masks of the used states and of the states below the current row.
    always_comb
    begin
        for (int k = 0; k < MAX_STATES; k++)
        begin
            used_mask[k]  = (k < 32'(n_used));
            lower_mask[k] = (k < 32'(i_idx));
        end
    end

    // Initial row: mark every used state whose acceptance differs from row i.
    assign init_row = (acc_reg[i_idx] ? ~acc_reg : acc_reg) & used_mask;

    // Successor pair test: a successor outside the used states reads unmarked.
    assign succ_ok     = (32'(ti_reg) < 32'(n_used)) && (32'(tj_reg) < 32'(n_used));
    assign succ_marked = succ_ok && row_a_reg[SW'(tj_reg)];
    assign mark_now    = succ_marked && !row_b_reg[j_idx];

    assign mx_we    = cmd.init_row || (cmd.upd && mark_now);
    assign mx_wdata = cmd.init_row ? init_row
                                   : (row_b_reg | (MAX_STATES'(1) << j_idx));

    // Pair matrix memory: row i written, rows of the successor and of i read.
    always_ff @(posedge clk)
    begin
        if (mx_we)
            mx_mem[i_idx] <= mx_wdata;
        if (cmd.mx_rd)
            row_a_reg <= mx_mem[SW'(ti_reg)];
        if (cmd.mx_rd || cmd.row_rd)
            row_b_reg <= mx_mem[i_idx];
    end

    // Pass change flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chg_reg <= 1'b0;
        else if (cmd.clr_chg)
            chg_reg <= 1'b0;
        else if (cmd.upd && mark_now)
            chg_reg <= 1'b1;
    end

    // Smallest lower state not told apart from state i; i itself if none.
    always_comb
    begin
        rep = i_idx;
        for (int k = MAX_STATES - 1; k >= 0; k--)
        begin
            if (lower_mask[k] && !row_b_reg[k])
                rep = SW'(k);
        end
    end

    assign leader = ((~row_b_reg & lower_mask) == '0);

    // Class counter.
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_clr)
            cnt_reg <= '0;
        else if (cmd.cnt_inc && leader)
            cnt_reg <= cnt_reg + NW'(1);
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (res_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_state_id       <= STATE_W'(i_idx);
            res_representative <= STATE_W'(rep);
            res_is_leader      <= leader;
            res_class_count    <= CLASS_W'(cnt_reg);
            res_last           <= cmd.emit_last;
        end
    end

    assign res_valid       = valid_reg;
    assign status.out_free = !valid_reg || res_ready;
    assign status.changed  = chg_reg || mark_now;

endmodule

[rtl/dfa_state_equivalence.sv]
// Top level of the DFA state-equivalence block (table-filling minimisation).
// Depends on dfase_pkg, dfase_item_if, dfase_result_if, dfase_ctrl and dfase_dp.
//
// Usage: the item channel carries load and run transactions. A transition or
// accepting-flag load is accepted in every cycle while the block is idle and
// produces no result. A run transaction is accepted and the item channel then
// holds ready low until the last result of that run sits in the result register.
// A run first builds the initial pair marks, then makes passes over every state
// pair for each of the m symbols (transition read, matrix row read, update)
// until a pass marks nothing: at most n passes when every transition stays
// inside the used states, and never more than n*(n-1)+1; then it counts the
// classes and delivers the n results, in ascending state order, the last one
// flagged. n and m are the configured state and symbol counts after clamping.
// When the receiver stalls, the result register holds and the sequencer waits;
// the block returns to idle, ready for loads, while its last result waits.
// Reset returns the sequencer to idle, empties the result register and sets
// both counts to one; the stored automaton is undefined until loaded.
module dfa_state_equivalence
    import dfase_pkg::*;
#(
    parameter int MAX_STATES  = MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    dfase_item_if.sink            item,
    dfase_result_if.source        result
);

    localparam int SW = $clog2(MAX_STATES);
    localparam int CW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int NW = $clog2(MAX_STATES + 1);

    dp_cmd_t       cmd;
    dp_status_t    status;
    logic          item_ready;
    logic          item_fire;
    logic [NW-1:0] n_used;
    logic [SW-1:0] i_idx, j_idx;
    logic [CW-1:0] c_idx;

    // Input handshake.
    assign item.ready = item_ready;
    assign item_fire  = item.valid && item_ready;

    dfase_ctrl #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_fire   (item_fire),
        .item_opcode (item.opcode),
        .item_ready  (item_ready),
        .n_used      (n_used),
        .i_idx       (i_idx),
        .j_idx       (j_idx),
        .c_idx       (c_idx),
        .cmd         (cmd),
        .status      (status)
    );

    dfase_dp #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .item_fire          (item_fire),
        .item_opcode        (item.opcode),
        .item_state_index   (item.state_index),
        .item_symbol_index  (item.symbol_index),
        .item_target_state  (item.target_state),
        .item_accept_flag   (item.accept_flag),
        .n_used             (n_used),
        .i_idx              (i_idx),
        .j_idx              (j_idx),
        .c_idx              (c_idx),
        .res_valid          (result.valid),
        .res_ready          (result.ready),
        .res_state_id       (result.state_id),
        .res_representative (result.representative),
        .res_is_leader      (result.is_leader),
        .res_class_count    (result.class_count),
        .res_last           (result.last)
    );

endmodule

[rtl/dfase_checker.sv]
// Port-level checker for the DFA state-equivalence block, bound to the top level.
// Depends on dfase_pkg and on the top level dfa_state_equivalence.
module dfase_checker
    import dfase_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [STATE_W-1:0] result_state_id,
    input logic [STATE_W-1:0] result_representative,
    input logic               result_is_leader,
    input logic               result_last
);

    // A result that is not taken stays offered.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
    else $error("result transaction withdrawn before it was taken");

    // A representative never lies above the state it stands for.
    a_rep_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_representative <= result_state_id))
    else $error("representative above its state");

    // The leader flag agrees with the representative.
    a_leader: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_is_leader == (result_representative == result_state_id)))
    else $error("leader flag disagrees with representative");

    // While a run still has results to deliver, no new transaction is taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_last |-> !item_ready)
    else $error("item channel ready in the middle of a run");

endmodule

bind dfa_state_equivalence dfase_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .item_ready            (item.ready),
    .result_valid          (result.valid),
    .result_ready          (result.ready),
    .result_state_id       (result.state_id),
    .result_representative (result.representative),
    .result_is_leader      (result.is_leader),
    .result_last           (result.last)
);

[bench/dfa_state_equivalence_tb.sv]
// Self-checking testbench for dfa_state_equivalence: loads directed, structured and
// random automata, runs table-filling minimisation and checks every per-state result.
// Depends on dfase_pkg, dfase_item_if, dfase_result_if and the block itself.
module dfa_state_equivalence_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfase_pkg::*;

    localparam int NST  = MAX_STATES_DEF;
    localparam int NSYM = MAX_SYMBOLS_DEF;

    // Opcode with no meaning to the block; such a transaction must be dropped.
    localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;

    typedef enum int {
        PACE_FREE,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH_LIGHT
    } pace_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [STATE_W-1:0]  state_index;
        logic [SYMBOL_W-1:0] symbol_index;
        logic [STATE_W-1:0]  target_state;
        logic                accept_flag;
    } dfa_cmd_t;

    localparam int CMD_W = $bits(dfa_cmd_t);

    typedef struct packed {
        logic [STATE_W-1:0] state_id;
        logic [STATE_W-1:0] representative;
        logic               is_leader;
        logic [CLASS_W-1:0] class_count;
        logic               last;
    } class_info_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    dfa_cmd_t              cmd_drv   = '0;
    logic                  cmd_valid = 1'b0;
    logic                  res_ready = 1'b0;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int errors         = 0;

    // Transactions waiting to be driven, and per-state results still owed.
    dfa_cmd_t    cmd_queue[$];
    class_info_t class_expect[$];

    // Predictor copy of the stored automaton and of the registers.
    logic [STATE_W-1:0]    model_trans [NST][NSYM];
    logic                  model_accept [NST];
    logic [NSTATES_W-1:0]  model_num_states  = 1;
    logic [NSYMBOLS_W-1:0] model_num_symbols = 1;

    // Stimulus-side view: which entries have been loaded, and the sizes in use.
    bit gen_trans_written [NST][NSYM];
    bit gen_accept_written [NST];
    int gen_states  = 1;
    int gen_symbols = 1;

    dfase_item_if   item_ch();
    dfase_result_if result_ch();

    assign item_ch.valid        = cmd_valid;
    assign item_ch.opcode       = cmd_drv.opcode;
    assign item_ch.state_index  = cmd_drv.state_index;
    assign item_ch.symbol_index = cmd_drv.symbol_index;
    assign item_ch.target_state = cmd_drv.target_state;
    assign item_ch.accept_flag  = cmd_drv.accept_flag;
    assign result_ch.ready      = res_ready;

    dfa_state_equivalence uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Zero counts as one and anything above the maximum as the maximum.
    function automatic int clamp_count(int value, int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    // Table filling on the predictor's copy; queues one result per used state.
    function automatic void predict_run();
        logic [NST-1:0] distinct [NST];
        int rep [NST];
        int n, m, classes, ti, tj;
        bit changed;
        class_info_t info;
        n = clamp_count(int'(model_num_states), NST);
        m = clamp_count(int'(model_num_symbols), NSYM);
        for (int i = 0; i < NST; i++)
            distinct[i] = '0;
        // Pairs that differ in acceptance are told apart by the empty string.
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (model_accept[i] != model_accept[j])
                    distinct[i][j] = 1'b1;
        // Propagate marks back through the transitions until a sweep adds none.
        // A successor outside the used states never counts as marked.
        do
        begin
            changed = 1'b0;
            for (int c = 0; c < m; c++)
                for (int i = 0; i < n; i++)
                begin
                    ti = int'(model_trans[i][c]);
                    for (int j = 0; j < n; j++)
                    begin
                        tj = int'(model_trans[j][c]);
                        if (ti < n && tj < n && distinct[ti][tj] && !distinct[i][j])
                        begin
                            distinct[i][j] = 1'b1;
                            changed = 1'b1;
                        end
                    end
                end
        end
        while (changed);
        // The representative is the lowest state not told apart from this one.
        classes = 0;
        for (int i = 0; i < n; i++)
        begin
            rep[i] = i;
            for (int j = 0; j < i; j++)
                if (!distinct[i][j])
                begin
                    rep[i] = j;
                    break;
                end
            if (rep[i] == i)
                classes++;
        end
        for (int i = 0; i < n; i++)
        begin
            info.state_id       = STATE_W'(i);
            info.representative = STATE_W'(rep[i]);
            info.is_leader      = (rep[i] == i);
            info.class_count    = CLASS_W'(classes);
            info.last           = (i == n - 1);
            class_expect.push_back(info);
        end
    endfunction

    // Effect of one accepted transaction on the predictor.
    function automatic void apply_command(dfa_cmd_t cmd);
        case (cmd.opcode)
            OP_LOAD_TRANS:  model_trans[cmd.state_index][cmd.symbol_index] = cmd.target_state;
            OP_LOAD_ACCEPT: model_accept[cmd.state_index] = cmd.accept_flag;
            OP_RUN:         predict_run();
            default:        ;
        endcase
    endfunction

    // Stimulus builders; fields that the opcode does not use carry random values.
    function automatic void queue_trans(int s, int sym, int tgt);
        dfa_cmd_t cmd;
        cmd              = CMD_W'($urandom);
        cmd.opcode       = OP_LOAD_TRANS;
        cmd.state_index  = STATE_W'(s);
        cmd.symbol_index = SYMBOL_W'(sym);
        cmd.target_state = STATE_W'(tgt);
        gen_trans_written[s][sym] = 1'b1;
        cmd_queue.push_back(cmd);
    endfunction

    function automatic void queue_accept(int s, bit flag);
        dfa_cmd_t cmd;
        cmd             = CMD_W'($urandom);
        cmd.opcode      = OP_LOAD_ACCEPT;
        cmd.state_index = STATE_W'(s);
        cmd.accept_flag = flag;
        gen_accept_written[s] = 1'b1;
        cmd_queue.push_back(cmd);
    endfunction

    function automatic void queue_ignored();
        dfa_cmd_t cmd;
        cmd        = CMD_W'($urandom);
        cmd.opcode = OP_IGNORED;
        cmd_queue.push_back(cmd);
    endfunction

    // A run never reads an entry that was not loaded: fill any gap first.
    function automatic void queue_run();
        dfa_cmd_t cmd;
        for (int s = 0; s < gen_states; s++)
        begin
            if (!gen_accept_written[s])
                queue_accept(s, 1'($urandom_range(0, 1)));
            for (int sym = 0; sym < gen_symbols; sym++)
                if (!gen_trans_written[s][sym])
                    queue_trans(s, sym, $urandom_range(0, NST - 1));
        end
        cmd        = CMD_W'($urandom);
        cmd.opcode = OP_RUN;
        cmd_queue.push_back(cmd);
    endfunction

    // Builds an automaton with planted equivalent states: each state copies the
    // behaviour of its class, with an occasional stray transition to spoil it.
    function automatic void queue_structured();
        int cls_of [NST];
        bit cls_accept [NST];
        int cls_next [NST][NSYM];
        int cand[$];
        int k, swap_idx, held, tgt;
        k = $urandom_range(1, gen_states);
        for (int s = 0; s < gen_states; s++)
            cls_of[s] = (s < k) ? s : $urandom_range(0, k - 1);
        for (int s = gen_states - 1; s > 0; s--)
        begin
            swap_idx         = $urandom_range(0, s);
            held             = cls_of[s];
            cls_of[s]        = cls_of[swap_idx];
            cls_of[swap_idx] = held;
        end
        for (int g = 0; g < k; g++)
        begin
            cls_accept[g] = 1'($urandom_range(0, 1));
            for (int sym = 0; sym < gen_symbols; sym++)
                cls_next[g][sym] = $urandom_range(0, k - 1);
        end
        for (int s = 0; s < gen_states; s++)
        begin
            queue_accept(s, cls_accept[cls_of[s]]);
            for (int sym = 0; sym < gen_symbols; sym++)
            begin
                if ($urandom_range(0, 9) == 0)
                    tgt = $urandom_range(0, NST - 1);
                else
                begin
                    cand.delete();
                    for (int t = 0; t < gen_states; t++)
                        if (cls_of[t] == cls_next[cls_of[s]][sym])
                            cand.push_back(t);
                    tgt = cand[$urandom_range(0, cand.size() - 1)];
                end
                queue_trans(s, sym, tgt);
            end
        end
        queue_run();
    endfunction

    // A few random edits, some outside the used states, then a run.
    function automatic void queue_tweaks();
        int pick, s;
        repeat ($urandom_range(1, 4))
        begin
            pick = $urandom_range(0, 9);
            s    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NST - 1)
                                               : $urandom_range(0, gen_states - 1);
            if (pick < 5)
                queue_trans(s, $urandom_range(0, gen_symbols - 1), $urandom_range(0, NST - 1));
            else if (pick < 8)
                queue_accept(s, 1'($urandom_range(0, 1)));
            else if (pick == 8)
                queue_ignored();
            else
                queue_trans(s, $urandom_range(0, NSYM - 1), $urandom_range(0, NST - 1));
        end
        queue_run();
    endfunction

    task automatic write_register(cfg_reg_t idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        if (idx == REG_NUM_STATES)
        begin
            model_num_states = NSTATES_W'(value);
            gen_states       = clamp_count(int'(model_num_states), NST);
        end
        else
        begin
            model_num_symbols = NSYMBOLS_W'(value);
            gen_symbols       = clamp_count(int'(model_num_symbols), NSYM);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Idle means nothing left to send and no result still owed, plus a margin
    // for the last load to settle.
    task automatic wait_for_idle();
        while (cmd_queue.size() != 0 || cmd_valid || class_expect.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_pace(pace_t pace);
        send_gap_pct   = (pace == PACE_SEND_GAPS) ? 63 : (pace == PACE_BOTH_LIGHT) ? 7 : 0;
        recv_stall_pct = (pace == PACE_RECV_STALLS) ? 63 : (pace == PACE_BOTH_LIGHT) ? 7 : 0;
    endtask

    task automatic run_phase(int states_val, int symbols_val, pace_t pace,
                             int rebuilds, int tweaks);
        wait_for_idle();
        write_register(REG_NUM_STATES, states_val);
        write_register(REG_NUM_SYMBOLS, symbols_val);
        @(negedge clk);
        set_pace(pace);
        repeat (rebuilds) queue_structured();
        repeat (tweaks) queue_tweaks();
    endtask

    // Item driver: presents the next pending transaction once the last one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_drv   <= '0;
        end
        else
        begin
            if (cmd_valid && item_ch.ready)
                apply_command(cmd_drv);
            if (!cmd_valid || item_ch.ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    cmd_drv   <= cmd_queue.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result monitor: checks each accepted transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (result_ch.valid && res_ready)
            begin
                if (class_expect.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual state %0d",
                             $time, result_ch.state_id);
                    errors++;
                end
                else
                begin
                    class_info_t want;
                    want = class_expect.pop_front();
                    compare_field("state_id", 8'(want.state_id), 8'(result_ch.state_id));
                    compare_field("representative", 8'(want.representative),
                                  8'(result_ch.representative));
                    compare_field("is_leader", 8'(want.is_leader), 8'(result_ch.is_leader));
                    compare_field("class_count", 8'(want.class_count),
                                  8'(result_ch.class_count));
                    compare_field("last", 8'(want.last), 8'(result_ch.last));
                end
            end
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stimulus sequence: directed cases first, then random phases.
    initial
    begin
        dfa_cmd_t all_ones;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset sizes: one state, one symbol. Extreme indexes, a target outside
        // the used states, an unknown opcode and the single-state run.
        queue_trans(NST - 1, NSYM - 1, NST - 1);
        queue_accept(NST - 1, 1'b0);
        queue_trans(0, 0, NST - 1);
        queue_accept(0, 1'b1);
        all_ones = '1;
        cmd_queue.push_back(all_ones);
        queue_run();

        // Zero in both registers counts as one.
        wait_for_idle();
        write_register(REG_NUM_STATES, 0);
        write_register(REG_NUM_SYMBOLS, 0);
        @(negedge clk);
        queue_trans(0, 0, 0);
        queue_run();

        // Three states where 0 and 2 are equivalent; state 1 also jumps outside.
        wait_for_idle();
        write_register(REG_NUM_STATES, 3);
        write_register(REG_NUM_SYMBOLS, 2);
        @(negedge clk);
        queue_accept(0, 1'b0);
        queue_accept(1, 1'b1);
        queue_accept(2, 1'b0);
        queue_trans(0, 0, 1);
        queue_trans(0, 1, 2);
        queue_trans(1, 0, 1);
        queue_trans(1, 1, 9);
        queue_trans(2, 0, 1);
        queue_trans(2, 1, 0);
        queue_run();

        // Random phases across sizes and flow-control patterns, extremes included.
        run_phase(2, 1, PACE_SEND_GAPS, 1, 2);
        run_phase(4, 2, PACE_RECV_STALLS, 1, 1);
        run_phase(16, 1, PACE_FREE, 1, 0);
        run_phase(31, 0, PACE_BOTH_LIGHT, 0, 1);
        run_phase(0, 9, PACE_SEND_GAPS, 1, 1);
        run_phase(5, 3, PACE_FREE, 1, 1);
        run_phase(8, 1, PACE_RECV_STALLS, 1, 1);
        run_phase(3, 2, PACE_BOTH_LIGHT, 0, 1);

        wait_for_idle();
        repeat (20) @(posedge clk);
        if (errors == 0 && class_expect.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: reports an error and ends the simulation if it is still running.
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[dfa_state_equivalence.f]
rtl/dfase_pkg.sv
rtl/dfase_item_if.sv
rtl/dfase_result_if.sv
rtl/dfase_ctrl.sv
rtl/dfase_dp.sv
rtl/dfa_state_equivalence.sv
rtl/dfase_checker.sv
bench/dfa_state_equivalence_tb.sv
